>>> hdl/ncc_window_score_assert.svh
// Assertion macros for the correlation score block.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef NCC_WINDOW_SCORE_ASSERT_SVH
`define NCC_WINDOW_SCORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define NCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ncc_ws_pkg.sv
// Shared types, constants and arithmetic helpers for the correlation score block.
// No dependencies; the interfaces and every module import this package.
`default_nettype none

package ncc_ws_pkg;

  localparam int PIX_W     = 32;
  localparam int SUM_W     = 24;
  localparam int DOT_W     = 18;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int SCORE_W   = 17;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = $clog2(FRAC_BITS);

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1 << FRAC_BITS);

  // Running sums of one window
  typedef struct packed {
    logic [SUM_W-1:0] cross_sum;
    logic [SUM_W-1:0] match_energy;
    logic [SUM_W-1:0] template_energy;
  } sums_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_CHK,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // Four-lane unsigned byte dot product
  function automatic logic [DOT_W-1:0] dot4(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [DOT_W-1:0] acc;
    logic [15:0]      prod;
    acc = '0;
    for (int lane = 0; lane < 4; lane++) begin
      prod = {8'd0, a[lane*8 +: 8]} * {8'd0, b[lane*8 +: 8]};
      acc  = acc + DOT_W'(prod);
    end
    return acc;
  endfunction

  // Add a term to a sum, saturating at the top of the sum range
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [DOT_W-1:0] term);
    logic [SUM_W:0] s;
    s = {1'b0, sum} + (SUM_W+1)'(term);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Full-width product of two sums
  function automatic logic [PROD_W-1:0] prod_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = {{SUM_W{1'b0}}, a} * {{SUM_W{1'b0}}, b};
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ncc_ws_if.sv
// Valid/ready channel interfaces for the pixel word input and the score output.
// Depends on ncc_ws_pkg for field widths.
`default_nettype none

interface ncc_ws_in_if import ncc_ws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] template_pixels;
  logic [PIX_W-1:0] match_pixels;
  logic             last_word;

  modport source (output valid, template_pixels, match_pixels, last_word, input ready);
  modport sink   (input valid, template_pixels, match_pixels, last_word, output ready);
endinterface

interface ncc_ws_out_if import ncc_ws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               zero_energy;

  modport source (output valid, score, zero_energy, input ready);
  modport sink   (input valid, score, zero_energy, output ready);
endinterface

`default_nettype wire

>>> hdl/ncc_ws_accum.sv
// Front end: accepts pixel words and accumulates the three window sums.
// Depends on ncc_ws_pkg and ncc_ws_in_if; hands finished windows to the queue.
`default_nettype none

module ncc_ws_accum import ncc_ws_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ncc_ws_in_if.sink  in_ch,
  output logic       push_valid,
  output sums_t      push_data,
  input  wire logic  push_ready
);

  sums_t sums_r, sums_nxt, sums_add;
  logic  accept;

  // Take a word whenever the queue has room for a finished window
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // Add this word's dot products into the running sums
  always_comb begin
    sums_add.cross_sum       = sat_add(sums_r.cross_sum,
                                       dot4(in_ch.template_pixels, in_ch.match_pixels));
    sums_add.match_energy    = sat_add(sums_r.match_energy,
                                       dot4(in_ch.match_pixels, in_ch.match_pixels));
    sums_add.template_energy = sat_add(sums_r.template_energy,
                                       dot4(in_ch.template_pixels, in_ch.template_pixels));
  end

  // Hand the completed sums over on the last word of a window
  assign push_valid = in_ch.valid && in_ch.last_word;
  assign push_data  = sums_add;

  // Advance on every accepted word, clear after the last one
  always_comb begin
    sums_nxt = sums_r;
    if (accept) begin
      sums_nxt = in_ch.last_word ? '0 : sums_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else begin
      sums_r <= sums_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ncc_ws_queue.sv
// Short queue of finished window sums between front and back end.
// Depends on ncc_ws_pkg for the sums type.
`default_nettype none

module ncc_ws_queue import ncc_ws_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  input  wire sums_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  output sums_t      pop_data,
  input  wire logic  pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sums_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ncc_ws_divide.sv
// Back end: squares and multiplies the sums, then divides one quotient bit per cycle.
// Depends on ncc_ws_pkg; drives the score output register.
`default_nettype none

module ncc_ws_divide import ncc_ws_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  input  wire sums_t       pop_data,
  output logic             pop_ready,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [SCORE_W-1:0] res_score,
  output logic             res_zero
);

  back_state_t        state_r, state_nxt;
  sums_t              sums_r;
  logic [PROD_W-1:0]  num_r, den_r, rem_r;
  logic               zero_r;
  logic [SCORE_W-1:0] quo_r, score_r;
  logic               flag_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               over, ge_one, step_ge;
  logic [PROD_W:0]    rem2, rem2_sub;
  logic [SCORE_W-1:0] quo_step;

  // Divider datapath: overflow test, first bit and one restoring step
  always_comb begin
    over     = {1'b0, num_r} >= {den_r, 1'b0};
    ge_one   = num_r >= den_r;
    rem2     = {rem_r, 1'b0};
    step_ge  = rem2 >= {1'b0, den_r};
    rem2_sub = rem2 - {1'b0, den_r};
    quo_step = {quo_r[SCORE_W-2:0], step_ge};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_CHK;
      BK_CHK:  state_nxt = (zero_r || over) ? BK_OUT : BK_DIV;
      BK_DIV:  if (cnt_r == '0) state_nxt = BK_OUT;
      BK_OUT:  if (res_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_ready = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      BK_IDLE: pop_ready = 1'b1;
      BK_OUT:  res_valid = 1'b1;
      default: begin
        pop_ready = 1'b0;
        res_valid = 1'b0;
      end
    endcase
  end

  assign res_score = score_r;
  assign res_zero  = flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          sums_r <= pop_data;
        end
      end
      BK_MUL: begin
        num_r  <= prod_sum(sums_r.cross_sum, sums_r.cross_sum);
        den_r  <= prod_sum(sums_r.match_energy, sums_r.template_energy);
        zero_r <= (sums_r.match_energy == '0) || (sums_r.template_energy == '0);
      end
      BK_CHK: begin
        // Zero energy gives a zero score; a quotient at or above two clamps to one; otherwise seed the integer bit
        flag_r <= zero_r;
        if (zero_r) begin
          score_r <= '0;
        end else if (over) begin
          score_r <= SCORE_ONE;
        end else begin
          quo_r <= SCORE_W'(ge_one);
          rem_r <= ge_one ? (num_r - den_r) : num_r;
          cnt_r <= CNT_W'(FRAC_BITS - 1);
        end
      end
      BK_DIV: begin
        quo_r <= quo_step;
        rem_r <= step_ge ? rem2_sub[PROD_W-1:0] : rem2[PROD_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          score_r <= (quo_step > SCORE_ONE) ? SCORE_ONE : quo_step;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/ncc_window_score.sv
// Squared normalized cross-correlation score over windows of packed pixel words.
// Input channel in_ch: one word per item, four template bytes and four match
// bytes (byte 0 in the low bits), last_word marking the end of a window.
// Output channel out_ch: one item per window, score in unsigned Q1.16
// (65536 = 1.0, truncated) and zero_energy when either energy sum was zero.
// The front end takes one word per cycle while the queue has room and folds it
// into three saturating 24-bit sums. On the last word the sums go into a queue
// of QUEUE_DEPTH windows. The back end handles one window at a time: pop, a
// multiply step, a check step, a one-bit-per-cycle restoring divider and an
// output step. Zero-energy windows and windows whose ratio reaches two skip the
// divider. Windows that arrive faster than the back end finishes them stall the
// input once the queue is full.
// A stalled receiver holds the score in the output register; the front end keeps
// taking words until the queue fills, then drops in_ch.ready.
// Reset (synchronous, active low) clears the sums, the queue and the sequencer.
// Depends on ncc_ws_pkg, ncc_ws_if, ncc_ws_accum, ncc_ws_queue, ncc_ws_divide.
`default_nettype none

module ncc_window_score import ncc_ws_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ncc_ws_in_if.sink    in_ch,
  ncc_ws_out_if.source out_ch
);

  logic  push_valid, push_ready;
  logic  pop_valid, pop_ready;
  sums_t push_data, pop_data;

  ncc_ws_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  ncc_ws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  ncc_ws_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_score (out_ch.score),
    .res_zero  (out_ch.zero_energy)
  );

endmodule

`default_nettype wire

>>> hdl/ncc_ws_checker.sv
// Port-level checker for the correlation score block, bound to the top level.
// Depends on ncc_ws_pkg and the macros in ncc_window_score_assert.svh.
`default_nettype none
`include "ncc_window_score_assert.svh"

module ncc_ws_checker import ncc_ws_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [SCORE_W-1:0] out_score,
  input wire logic               out_zero_energy
);

  // Hold a stalled result
  `NCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_score) && $stable(out_zero_energy), "stalled score changed")

  // Zero energy forces a zero score
  `NCC_ASSERT_NOW(a_zero_score, out_valid && out_zero_energy, out_score == '0, "zero energy with nonzero score")

  // Score never exceeds one
  `NCC_ASSERT_NOW(a_score_max, out_valid, out_score <= SCORE_ONE, "score above one")

endmodule

bind ncc_window_score ncc_ws_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_score       (out_ch.score),
  .out_zero_energy (out_ch.zero_energy)
);

`default_nettype wire
